// ===== rtl/core/lzss_pkg.sv =====
package lzss_pkg;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int MIN_MATCH_DEF    = 3;

    // Fixed widths set by the stream format.
    localparam int POS_W  = 16;
    localparam int DIST_W = 12;
    localparam int CNT_W  = 13;
    localparam int LEN_W  = 5;

    localparam logic [POS_W-1:0] HDR_ADJUST = 16'd2;
    localparam logic [3:0]       FLAG_COUNT = 4'd8;

    typedef enum logic [3:0] {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_MARK,
        PH_NEW_LO,
        PH_NEW_HI,
        PH_ITEM,
        PH_TOK_HI,
        PH_COPY,
        PH_FIN,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_FINISHED = 2'd1,
        ST_BADDIST  = 2'd2
    } t_status;

endpackage

// ===== rtl/core/lzss_ram.sv =====
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lzss_stream_decompressor.sv =====
// Each accepted item's result is registered in the output register; for a copy, the history
// read is registered in the RAM first, and the first byte then goes into the output register.
// The high byte of a copy token of length L (3 to 18) starts a copy of L history bytes, one
// history byte per cycle while the output is not stalled; a finish after data is a separate result.
// Reset: i_rst_n is synchronous, active low, and clears all control state but r_src at once; the
// history RAM is not cleared, there is no clearing pass, and the block is ready right after.
module lzss_stream_decompressor #(
    parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEF,
    parameter int MIN_MATCH    = lzss_pkg::MIN_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [1:0] o_out_status
);

    // Address width of the history window and width of the fill counter, which
    // saturates at the window depth.
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int PW = $clog2(WINDOW_DEPTH + 1);

    // Control state. The position counts every byte consumed until the stream finishes, headers included.
    lzss_pkg::t_phase                 r_phase, n_phase;
    logic [lzss_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [lzss_pkg::POS_W-1:0]       r_end, n_end;
    logic [7:0]                       r_partial, n_partial;
    logic [7:0]                       r_flags, n_flags;
    logic [3:0]                       r_fidx, n_fidx;
    logic [AW-1:0]                    r_wp, n_wp;
    logic [PW-1:0]                    r_prod, n_prod;
    logic [AW-1:0]                    r_src, n_src;
    logic [lzss_pkg::LEN_W-1:0]       r_remain, n_remain;

    // Forwarding of a history write that hits the entry being read in the same cycle;
    // this happens for a copy at distance one.
    logic                             r_fwd;
    logic [7:0]                       r_fwd_data;

    // Output register, which parts the result side from the input side.
    logic                             r_out_valid;
    logic [7:0]                       r_out_byte;
    logic                             r_out_last;
    lzss_pkg::t_status                r_out_status;

    // Result produced this cycle.
    logic                             emit;
    logic [7:0]                       emit_byte;
    logic                             emit_last;
    lzss_pkg::t_status                emit_status;

    // History RAM port signals.
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [7:0]                       ram_wdata;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [7:0]                       ram_rdata;

    logic                             slot_free;
    logic                             in_acc;
    logic [lzss_pkg::POS_W-1:0]       pos_inc;
    logic [lzss_pkg::POS_W-1:0]       hdr_end;
    logic [lzss_pkg::DIST_W-1:0]      tok_dist;
    logic                             dist_bad;
    logic [AW:0]                      src_sum;
    logic [AW-1:0]                    src_start;
    logic [AW-1:0]                    wp_inc;
    logic [PW-1:0]                    prod_inc;
    logic [7:0]                       copy_byte;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The output register can take a new result when it is empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;

    // Input is held off while a copy or a pending finish result owns the output, and
    // whenever the output register is full. Once finished, bytes are taken and dropped.
    assign o_in_stall = (r_phase == lzss_pkg::PH_COPY) || (r_phase == lzss_pkg::PH_FIN) ||
                        (!slot_free && (r_phase != lzss_pkg::PH_DONE));
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pos_inc = r_pos + 16'd1;
    assign hdr_end = {i_in_byte, r_partial} + lzss_pkg::HDR_ADJUST;

    // Copy distance check: zero, or reaching back past the bytes produced so far.
    assign tok_dist = {i_in_byte[3:0], r_partial};
    assign dist_bad = (tok_dist == '0) ||
                      ({1'b0, tok_dist} > lzss_pkg::CNT_W'(r_prod));

    // Start of the copy in the circular window; valid only when the distance passed.
    assign src_sum   = (AW+1)'(r_wp) + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(tok_dist);
    assign src_start = (src_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                       AW'(src_sum - (AW+1)'(WINDOW_DEPTH)) : src_sum[AW-1:0];

    assign wp_inc   = (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign prod_inc = (r_prod == PW'(WINDOW_DEPTH)) ? r_prod : r_prod + 1'b1;

    assign copy_byte = r_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_end       = r_end;
        n_partial   = r_partial;
        n_flags     = r_flags;
        n_fidx      = r_fidx;
        n_wp        = r_wp;
        n_prod      = r_prod;
        n_src       = r_src;
        n_remain    = r_remain;
        emit        = 1'b0;
        emit_byte   = 8'd0;
        emit_last   = 1'b1;
        emit_status = lzss_pkg::ST_DATA;
        ram_we      = 1'b0;
        ram_waddr   = r_wp;
        ram_wdata   = i_in_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_src;

        if (in_acc && (r_phase != lzss_pkg::PH_DONE)) begin
            n_pos = pos_inc;
        end

        unique case (r_phase)
            lzss_pkg::PH_HDR_LO: begin
                if (in_acc) begin
                    n_partial = i_in_byte;
                    n_phase   = lzss_pkg::PH_HDR_HI;
                end
            end
            lzss_pkg::PH_HDR_HI: begin
                if (in_acc) begin
                    n_end  = hdr_end;
                    n_fidx = lzss_pkg::FLAG_COUNT;
                    if (pos_inc > hdr_end) begin
                        emit        = 1'b1;
                        emit_status = lzss_pkg::ST_FINISHED;
                        n_phase     = lzss_pkg::PH_DONE;
                    end else if (pos_inc == hdr_end) begin
                        n_phase = lzss_pkg::PH_MARK;
                    end else begin
                        n_phase = lzss_pkg::PH_ITEM;
                    end
                end
            end
            lzss_pkg::PH_MARK: begin
                if (in_acc) begin
                    if (i_in_byte == 8'd0) begin
                        emit        = 1'b1;
                        emit_status = lzss_pkg::ST_FINISHED;
                        n_phase     = lzss_pkg::PH_DONE;
                    end else begin
                        n_phase = lzss_pkg::PH_NEW_LO;
                    end
                end
            end
            lzss_pkg::PH_NEW_LO: begin
                if (in_acc) begin
                    n_partial = i_in_byte;
                    n_phase   = lzss_pkg::PH_NEW_HI;
                end
            end
            lzss_pkg::PH_NEW_HI: begin
                if (in_acc) begin
                    n_end   = {i_in_byte, r_partial};
                    n_fidx  = lzss_pkg::FLAG_COUNT;
                    n_phase = lzss_pkg::PH_ITEM;
                end
            end
            lzss_pkg::PH_ITEM: begin
                if (in_acc) begin
                    if (r_fidx[3]) begin
                        // Flag byte.
                        n_flags = i_in_byte;
                        n_fidx  = '0;
                        if (pos_inc > r_end) begin
                            emit        = 1'b1;
                            emit_status = lzss_pkg::ST_FINISHED;
                            n_phase     = lzss_pkg::PH_DONE;
                        end else if (pos_inc == r_end) begin
                            n_phase = lzss_pkg::PH_MARK;
                        end else begin
                            n_phase = lzss_pkg::PH_ITEM;
                        end
                    end else if (r_flags[r_fidx[2:0]]) begin
                        // Low byte of a copy token.
                        n_partial = i_in_byte;
                        n_phase   = lzss_pkg::PH_TOK_HI;
                    end else begin
                        // Literal: into the history and out as data.
                        ram_we    = 1'b1;
                        n_wp      = wp_inc;
                        n_prod    = prod_inc;
                        n_fidx    = r_fidx + 4'd1;
                        emit      = 1'b1;
                        emit_byte = i_in_byte;
                        if (pos_inc > r_end) begin
                            emit_last = 1'b0;
                            n_phase   = lzss_pkg::PH_FIN;
                        end else if (pos_inc == r_end) begin
                            n_phase = lzss_pkg::PH_MARK;
                        end else begin
                            n_phase = lzss_pkg::PH_ITEM;
                        end
                    end
                end
            end
            lzss_pkg::PH_TOK_HI: begin
                if (in_acc) begin
                    n_fidx = r_fidx + 4'd1;
                    if (dist_bad) begin
                        emit        = 1'b1;
                        emit_status = lzss_pkg::ST_BADDIST;
                        n_phase     = lzss_pkg::PH_DONE;
                    end else begin
                        // Issue the first history read of the copy.
                        ram_re    = 1'b1;
                        ram_raddr = src_start;
                        n_src     = (src_start == AW'(WINDOW_DEPTH - 1)) ?
                                    '0 : src_start + 1'b1;
                        n_remain  = lzss_pkg::LEN_W'(i_in_byte[7:4]) +
                                    lzss_pkg::LEN_W'(MIN_MATCH);
                        n_phase   = lzss_pkg::PH_COPY;
                    end
                end
            end
            lzss_pkg::PH_COPY: begin
                // One byte per cycle while the output slot is free: the byte from the previous read is written
                // back at the write pointer and sent out while the next read is issued.
                if (slot_free) begin
                    ram_we    = 1'b1;
                    ram_wdata = copy_byte;
                    n_wp      = wp_inc;
                    n_prod    = prod_inc;
                    n_remain  = r_remain - 1'b1;
                    emit      = 1'b1;
                    emit_byte = copy_byte;
                    if (r_remain == lzss_pkg::LEN_W'(1)) begin
                        if (r_pos > r_end) begin
                            emit_last = 1'b0;
                            n_phase   = lzss_pkg::PH_FIN;
                        end else if (r_pos == r_end) begin
                            n_phase = lzss_pkg::PH_MARK;
                        end else begin
                            n_phase = lzss_pkg::PH_ITEM;
                        end
                    end else begin
                        emit_last = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = r_src;
                        n_src     = (r_src == AW'(WINDOW_DEPTH - 1)) ? '0 : r_src + 1'b1;
                    end
                end
            end
            lzss_pkg::PH_FIN: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    emit_status = lzss_pkg::ST_FINISHED;
                    n_phase     = lzss_pkg::PH_DONE;
                end
            end
            lzss_pkg::PH_DONE: begin
                n_phase = lzss_pkg::PH_DONE;
            end
            default: begin
                n_phase = lzss_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lzss_pkg::PH_HDR_LO;
            r_pos       <= '0;
            r_end       <= '0;
            r_partial   <= '0;
            r_flags     <= '0;
            r_fidx      <= lzss_pkg::FLAG_COUNT;
            r_wp        <= '0;
            r_prod      <= '0;
            r_remain    <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_end     <= n_end;
            r_partial <= n_partial;
            r_flags   <= n_flags;
            r_fidx    <= n_fidx;
            r_wp      <= n_wp;
            r_prod    <= n_prod;
            r_remain  <= n_remain;
            if (ram_re) begin
                r_fwd <= ram_we && (ram_waddr == ram_raddr);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        if (ram_re) begin
            r_fwd_data <= ram_wdata;
        end
        if (emit) begin
            r_out_byte   <= emit_byte;
            r_out_last   <= emit_last;
            r_out_status <= emit_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

`ifndef SYNTHESIS
    a_copy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lzss_pkg::PH_COPY) |-> (r_remain != '0))
        else $error("copy in progress with no bytes left");

    a_fill_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod <= PW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_quiet_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == lzss_pkg::PH_DONE) && !r_out_valid) |=> !r_out_valid)
        else $error("result produced after the stream finished");

    a_status_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != lzss_pkg::ST_DATA)) |-> (r_out_byte == 8'd0))
        else $error("nonzero byte on a status result");

    a_no_input_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == lzss_pkg::PH_COPY) && slot_free) |=> ($past(r_pos) == r_pos))
        else $error("input consumed during a copy");
`endif

endmodule
